### hdl/segment_charge_histogrammer_macros.svh
// Assertion macros shared by the segment charge histogrammer RTL.
`ifndef SEGMENT_CHARGE_HISTOGRAMMER_MACROS_SVH
`define SEGMENT_CHARGE_HISTOGRAMMER_MACROS_SVH

// Same-cycle implication, clocked on i_clk and switched off while i_rst_n is low.
`define SCH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and switched off while i_rst_n is low.
`define SCH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sch_pkg.sv
// Types and constants shared by the segment charge histogrammer modules.
`timescale 1ns / 1ps

package sch_pkg;

    localparam int POS_W      = 5;
    localparam int CRY_W      = 2;
    localparam int SEG_W      = 4;
    localparam int CHARGE_W   = 32;
    localparam int RBIN_W     = 10;
    localparam int POS_PAT_W  = 16;
    localparam int CRY_PAT_W  = 4;
    localparam int SEG_PAT_W  = 10;
    localparam int COUNT_W    = 32;

    // Widest row index and bin index over the allowed geometry.
    localparam int ROW_MAX_W  = 11;
    localparam int BIN_MAX_W  = 15;

    // Overflow bin sits this far below the top of the histogram.
    localparam int OVF_OFFSET = 10;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    typedef struct packed {
        logic                 mode;
        logic [POS_W-1:0]     position;
        logic [CRY_W-1:0]     crystal;
        logic [SEG_W-1:0]     segment;
        logic [CHARGE_W-1:0]  charge;
        logic [RBIN_W-1:0]    read_bin;
        logic                 array_has_hits;
        logic [POS_PAT_W-1:0] position_pattern;
        logic                 detector_has_hits;
        logic [CRY_PAT_W-1:0] crystal_pattern;
        logic                 crystal_has_energy;
        logic [SEG_PAT_W-1:0] segment_pattern;
    } t_item;

    typedef struct packed {
        logic                 is_read;
        logic                 count;
        logic                 zero;
        logic [ROW_MAX_W-1:0] row;
        logic [BIN_MAX_W-1:0] bin;
    } t_req;

endpackage

### hdl/sch_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sch_decode.sv
// Decodes one input transaction into a row, a bin and the hit gating result.
`timescale 1ns / 1ps

module sch_decode
    import sch_pkg::*;
#(
    parameter int POSITIONS = 16,
    parameter int CRYSTALS  = 4,
    parameter int SEGMENTS  = 10,
    parameter int BINS      = 1024
) (
    input  t_item i_item,
    output t_req  o_req
);

    logic                 w_pos_ok;
    logic                 w_cry_ok;
    logic                 w_seg_ok;
    logic                 w_addr_ok;
    logic [POS_W-2:0]     w_pos_m1;
    logic [ROW_MAX_W-1:0] w_row;
    logic [15:0]          w_seg_pat;
    logic                 w_gates;
    logic                 w_charge_in;
    logic [BIN_MAX_W-1:0] w_rec_bin;
    logic                 w_rbin_ok;

    assign w_pos_ok  = (i_item.position != '0) && (i_item.position <= POS_W'(POSITIONS));
    assign w_cry_ok  = {2'b00, i_item.crystal} < 4'(CRYSTALS);
    assign w_seg_ok  = {1'b0, i_item.segment} < 5'(SEGMENTS);
    assign w_addr_ok = w_pos_ok && w_cry_ok && w_seg_ok;

    assign w_pos_m1  = w_pos_ok ? (POS_W-1)'(i_item.position - POS_W'(1)) : '0;
    assign w_row     = ROW_MAX_W'((32'(w_pos_m1) * 32'(CRYSTALS) + 32'(i_item.crystal))
                       * 32'(SEGMENTS) + 32'(i_item.segment));

    assign w_seg_pat = {6'b000000, i_item.segment_pattern};
    assign w_gates   = i_item.array_has_hits && i_item.position_pattern[w_pos_m1]
                       && i_item.detector_has_hits && i_item.crystal_pattern[i_item.crystal]
                       && i_item.crystal_has_energy && w_seg_pat[i_item.segment];

    assign w_charge_in = !i_item.charge[CHARGE_W-1]
                         && (i_item.charge[CHARGE_W-2:0] < (CHARGE_W-1)'(BINS));
    assign w_rec_bin   = w_charge_in ? i_item.charge[BIN_MAX_W-1:0]
                                     : BIN_MAX_W'(BINS - OVF_OFFSET);
    assign w_rbin_ok   = {6'b000000, i_item.read_bin} < 16'(BINS);

    always_comb begin
        o_req.is_read = i_item.mode;
        o_req.count   = !i_item.mode && w_addr_ok && w_gates;
        o_req.zero    = !(w_addr_ok && w_rbin_ok);
        o_req.row     = w_addr_ok ? w_row : '0;
        if (i_item.mode) begin
            o_req.bin = (w_addr_ok && w_rbin_ok) ? BIN_MAX_W'(i_item.read_bin) : '0;
        end else begin
            o_req.bin = w_rec_bin;
        end
    end

endmodule

### hdl/sch_out_fifo.sv
// Small result queue between the update stage and the output stream.
`timescale 1ns / 1ps

module sch_out_fifo
    import sch_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [COUNT_W-1:0]   i_push_data,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [COUNT_W-1:0]   o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    logic [COUNT_W-1:0]   r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + OUT_CNT_W'(1);
                2'b01:   r_count <= r_count - OUT_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/segment_charge_histogrammer.sv
// A read result passes through stage one, stage two and the output queue before it is offered.
// Throughput: one transaction per cycle while input ready is high, through a read-modify-write
// pipeline on the counter RAM, with forwarding between back-to-back updates of the same counter.
// Input ready drops while four read results are outstanding.
// Reset: a clearing sweep writes one counter per cycle over all POSITIONS*CRYSTALS*SEGMENTS*BINS
// counters (655360 by default), and no input transaction is taken until it finishes.
`timescale 1ns / 1ps
`include "segment_charge_histogrammer_macros.svh"

module segment_charge_histogrammer
    import sch_pkg::*;
#(
    parameter int POSITIONS = 16,
    parameter int CRYSTALS  = 4,
    parameter int SEGMENTS  = 10,
    parameter int BINS      = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // position[4:0], crystal[6:5], segment[10:7], charge[42:11], read_bin[52:43],
    // array_has_hits[53], position_pattern[69:54], detector_has_hits[70],
    // crystal_pattern[74:71], crystal_has_energy[75], segment_pattern[85:76],
    // zero padding[87:86]
    input  logic [87:0]  i_s_axis_tdata,
    // mode[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // bin_count[31:0]
    output logic [31:0]  o_m_axis_tdata
);

    localparam int ROWS   = POSITIONS * CRYSTALS * SEGMENTS;
    localparam int DEPTH  = ROWS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIN_W  = $clog2(BINS);

    t_item                w_item;
    t_req                 w_req;
    logic                 w_accept;
    logic                 w_pop;

    logic                 r_clr_busy;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [OUT_CNT_W-1:0] r_credit;
    logic [OUT_CNT_W-1:0] n_credit;

    logic                 r_s1_valid;
    t_req                 r_s1;
    logic [ADDR_W-1:0]    w_s1_addr;

    logic                 r_s2_valid;
    logic                 r_s2_read;
    logic                 r_s2_cnt;
    logic                 r_s2_zero;
    logic [ADDR_W-1:0]    r_s2_addr;
    logic                 r_fwd_hit;
    logic [COUNT_W-1:0]   r_fwd_val;

    logic [COUNT_W-1:0]   w_rd_data;
    logic [COUNT_W-1:0]   w_cur;
    logic [COUNT_W-1:0]   w_inc;
    logic                 w_item_we;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [COUNT_W-1:0]   w_wr_data;
    logic                 w_push;
    logic [COUNT_W-1:0]   w_push_data;
    logic [OUT_CNT_W-1:0] w_fifo_count;

    always_comb begin
        w_item.mode               = i_s_axis_tuser;
        w_item.position           = i_s_axis_tdata[4:0];
        w_item.crystal            = i_s_axis_tdata[6:5];
        w_item.segment            = i_s_axis_tdata[10:7];
        w_item.charge             = i_s_axis_tdata[42:11];
        w_item.read_bin           = i_s_axis_tdata[52:43];
        w_item.array_has_hits     = i_s_axis_tdata[53];
        w_item.position_pattern   = i_s_axis_tdata[69:54];
        w_item.detector_has_hits  = i_s_axis_tdata[70];
        w_item.crystal_pattern    = i_s_axis_tdata[74:71];
        w_item.crystal_has_energy = i_s_axis_tdata[75];
        w_item.segment_pattern    = i_s_axis_tdata[85:76];
    end

    sch_decode #(
        .POSITIONS (POSITIONS),
        .CRYSTALS  (CRYSTALS),
        .SEGMENTS  (SEGMENTS),
        .BINS      (BINS)
    ) u_decode (
        .i_item (w_item),
        .o_req  (w_req)
    );

    assign o_s_axis_tready = i_rst_n && !r_clr_busy && (r_credit < OUT_CNT_W'(OUT_DEPTH));
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        case ({w_accept && w_req.is_read, w_pop})
            2'b10:   n_credit = r_credit + OUT_CNT_W'(1);
            2'b01:   n_credit = r_credit - OUT_CNT_W'(1);
            default: n_credit = r_credit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_credit   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_credit   <= n_credit;
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_fwd_hit  <= r_s1_valid && w_item_we && (w_s1_addr == r_s2_addr);
        end
    end

    // Stage one computes the counter address and issues the RAM read.
    assign w_s1_addr = ADDR_W'(ADDR_W'(r_s1.row[ROW_W-1:0]) * ADDR_W'(BINS))
                       + ADDR_W'(r_s1.bin[BIN_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_req;
        end
        r_s2_read <= r_s1.is_read;
        r_s2_cnt  <= r_s1.count;
        r_s2_zero <= r_s1.zero;
        r_s2_addr <= w_s1_addr;
        r_fwd_val <= w_inc;
    end

    sch_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_s1_addr),
        .o_rd_data (w_rd_data)
    );

    // Stage two takes the forwarded value when the previous update hit the same counter.
    assign w_cur       = r_fwd_hit ? r_fwd_val : w_rd_data;
    assign w_inc       = (&w_cur) ? w_cur : w_cur + COUNT_W'(1);
    assign w_item_we   = r_s2_valid && r_s2_cnt;
    assign w_we        = r_clr_busy || w_item_we;
    assign w_wr_addr   = r_clr_busy ? r_clr_addr : r_s2_addr;
    assign w_wr_data   = r_clr_busy ? '0 : w_inc;
    assign w_push      = r_s2_valid && r_s2_read;
    assign w_push_data = r_s2_zero ? '0 : w_cur;

    sch_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_ready     (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_data      (o_m_axis_tdata),
        .o_count     (w_fifo_count)
    );

    `SCH_ASSERT_IMP(a_credit_cap, 1'b1, r_credit <= OUT_CNT_W'(OUT_DEPTH), "credit above queue depth")
    `SCH_ASSERT_IMP(a_queue_credit, 1'b1, w_fifo_count <= r_credit, "queue holds uncredited result")
    `SCH_ASSERT_IMP(a_clear_idle, r_clr_busy, !r_s1_valid && !r_s2_valid, "update during clearing")
    `SCH_ASSERT_NXT(a_read_push, r_s1_valid && r_s1.is_read, w_push, "read result not queued")

endmodule
